>>> rtl/core/ope_pkg.sv
package ope_pkg;

	// fixed field widths
	localparam int CODE_W     = 16;
	localparam int ORD_W      = 4;
	localparam int DLY_CFG_W  = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EMBED_ORDER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EMBED_DELAY = 1'b1;

	// configuration reset values
	localparam logic [ORD_W-1:0]     ORDER_RST = 4'd3;
	localparam logic [DLY_CFG_W-1:0] DELAY_RST = 5'd1;

	// window queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// factorial weights of the lehmer code
	localparam logic [CODE_W-1:0] FACT_TAB [8] = '{
		16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040
	};

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

>>> rtl/core/ope_queue.sv
module ope_queue #(
	parameter int WIDTH = 132
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output ope_pkg::q_stat_t stat
);
	import ope_pkg::*;

	logic [WIDTH-1:0]  buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= din;
	end

	assign dout       = buf_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

>>> rtl/core/ope_front.sv
module ope_front #(
	parameter int MAX_ORDER   = 8,
	parameter int MAX_DELAY   = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sample_valid,
	input  logic signed [SAMPLE_BITS-1:0]           sample,
	output logic                                    sample_stall,
	input  logic                                    cfg_we,
	input  logic [ope_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [ope_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  ope_pkg::q_stat_t                        q_stat,
	output logic                                    push,
	output logic [MAX_ORDER-1:0][SAMPLE_BITS-1:0]   push_win,
	output logic [ope_pkg::ORD_W-1:0]               push_ord
);
	import ope_pkg::*;

	localparam int DEPTH  = (MAX_ORDER - 1) * MAX_DELAY + 1;
	localparam int AW     = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int DLY_W  = $clog2(MAX_DELAY + 1);

	logic [ORD_W-1:0]        order_q;
	logic [DLY_CFG_W-1:0]    delay_q;
	logic [AW-1:0]           head_q;
	logic [FILL_W-1:0]       fill_q;
	logic [ORD_W-1:0]        ord_eff;
	logic [DLY_W-1:0]        tau_eff;
	logic [FILL_W-1:0]       span;
	logic [FILL_W-1:0]       fill_nxt;
	logic                    acc;
	logic                    emit;
	logic                    v_s1;
	logic [SAMPLE_BITS-1:0]  newest_s1;
	logic [ORD_W-1:0]        ord_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_RST;
			delay_q <= DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EMBED_ORDER: order_q <= cfg_data[ORD_W-1:0];
				REG_EMBED_DELAY: delay_q <= cfg_data[DLY_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp settings into their legal ranges
	always_comb begin
		if (order_q < ORD_W'(2))
			ord_eff = ORD_W'(2);
		else if (32'(order_q) > MAX_ORDER)
			ord_eff = ORD_W'(MAX_ORDER);
		else
			ord_eff = order_q;

		if (delay_q == '0)
			tau_eff = DLY_W'(1);
		else if (32'(delay_q) > MAX_DELAY)
			tau_eff = DLY_W'(MAX_DELAY);
		else
			tau_eff = DLY_W'(delay_q);
	end

	// classify: does this sample complete a window
	assign span     = FILL_W'(ord_eff - ORD_W'(1)) * FILL_W'(tau_eff) + FILL_W'(1);
	assign fill_nxt = (fill_q == FILL_W'(DEPTH)) ? fill_q : fill_q + FILL_W'(1);
	assign emit     = (fill_nxt >= span);

	// hold off when the queue cannot take what is in flight
	assign sample_stall = ({1'b0, q_stat.count} + (QCNT_W + 1)'(v_s1))
		>= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign acc = sample_valid && !sample_stall;

	// history write pointer and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			v_s1 <= acc && emit;
			if (acc) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
				fill_q <= fill_nxt;
			end
		end
	end

	// newest sample and order travel alongside the reads
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			newest_s1 <= sample;
			ord_s1    <= ord_eff;
		end
	end

	// one history copy per older window tap
	for (genvar k = 1; k < MAX_ORDER; k++) begin : g_tap
		logic [SAMPLE_BITS-1:0] hist_mem [DEPTH];
		logic [AW-1:0]          age;
		logic [AW:0]            diff;
		logic [AW-1:0]          raddr;
		logic [SAMPLE_BITS-1:0] rd_s1;

		assign age   = AW'(k) * AW'(tau_eff);
		assign diff  = {1'b0, head_q} + (AW + 1)'(DEPTH) - {1'b0, age};
		assign raddr = (diff >= (AW + 1)'(DEPTH)) ? AW'(diff - (AW + 1)'(DEPTH)) : AW'(diff);

		always_ff @(posedge clk) begin
			if (acc)
				hist_mem[head_q] <= sample;
			if (acc && emit)
				rd_s1 <= hist_mem[raddr];
		end

		assign push_win[k] = rd_s1;
	end

	assign push_win[0] = newest_s1;
	assign push        = v_s1;
	assign push_ord    = ord_s1;

endmodule

>>> rtl/core/ope_back.sv
module ope_back #(
	parameter int MAX_ORDER   = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ope_pkg::q_stat_t                      q_stat,
	input  logic [MAX_ORDER-1:0][SAMPLE_BITS-1:0] q_win,
	input  logic [ope_pkg::ORD_W-1:0]             q_ord,
	output logic                                  q_pop,
	output logic                                  code_valid,
	output logic [ope_pkg::CODE_W-1:0]            pattern_code,
	input  logic                                  code_stall
);
	import ope_pkg::*;

	localparam int CW = $clog2(MAX_ORDER);

	logic [CW-1:0]     cnt_c  [MAX_ORDER];
	logic [CW-1:0]     cnt_s2 [MAX_ORDER];
	logic              v_s2;
	logic              code_valid_q;
	logic [CODE_W-1:0] pattern_code_q;
	logic [CODE_W-1:0] code_c;
	logic              o_rdy;
	logic              b_rdy;

	// stage advance
	assign o_rdy = !code_valid_q || !code_stall;
	assign b_rdy = !v_s2 || o_rdy;
	assign q_pop = !q_stat.empty && b_rdy;

	// tap a counts newer taps holding a smaller sample, masked beyond the order
	always_comb begin
		for (int a = 0; a < MAX_ORDER; a++) begin
			cnt_c[a] = '0;
			for (int b = 0; b < a; b++) begin
				if ($signed(q_win[b]) < $signed(q_win[a]))
					cnt_c[a] = cnt_c[a] + CW'(1);
			end
			if (!(ORD_W'(a) < q_ord))
				cnt_c[a] = '0;
		end
	end

	// factorial weighted sum
	always_comb begin
		code_c = '0;
		for (int a = 1; a < MAX_ORDER; a++)
			code_c = code_c + CODE_W'(CODE_W'(cnt_s2[a]) * FACT_TAB[a]);
	end

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2         <= 1'b0;
			code_valid_q <= 1'b0;
		end else begin
			if (b_rdy)
				v_s2 <= q_pop;
			if (o_rdy)
				code_valid_q <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop)
			cnt_s2 <= cnt_c;
		if (o_rdy && v_s2)
			pattern_code_q <= code_c;
	end

	assign code_valid   = code_valid_q;
	assign pattern_code = pattern_code_q;

endmodule

>>> rtl/core/ordinal_pattern_encoder_core.sv
// Ordinal pattern encoder: takes one signed sample per item and, once a full window of
// embed_order samples spaced embed_delay apart is held, gives the Lehmer code of the window's
// ordinal pattern (0 to order!-1, ties broken toward the earlier sample). Samples that do not
// complete a window give no result. One sample is taken every cycle while sample_stall is low;
// each result passes in turn through the history read, the window queue, the pairwise compares
// and the weighted sum into the output register. Each older window tap has its own copy of the
// sample history, written with every sample and read once per cycle, so all taps are fetched
// together. History needs no clearing after reset; in-order taps read only written samples.
// Settings must be changed only while no item is in flight; the block does not enforce it.
module ordinal_pattern_encoder_core #(
	parameter int MAX_ORDER   = 8,
	parameter int MAX_DELAY   = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic signed [SAMPLE_BITS-1:0]  sample,
	output logic                           sample_stall,
	output logic                           code_valid,
	output logic [ope_pkg::CODE_W-1:0]     pattern_code,
	input  logic                           code_stall,
	input  logic                           cfg_we,
	input  logic [ope_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ope_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ope_pkg::*;

	localparam int QW = MAX_ORDER * SAMPLE_BITS + ORD_W;

	logic                                  q_push;
	logic                                  q_pop;
	logic [MAX_ORDER-1:0][SAMPLE_BITS-1:0] push_win;
	logic [ORD_W-1:0]                      push_ord;
	logic [MAX_ORDER-1:0][SAMPLE_BITS-1:0] q_win;
	logic [ORD_W-1:0]                      q_ord;
	q_stat_t                               q_stat;

	// history, classification and tap reads
	ope_front #(
		.MAX_ORDER   (MAX_ORDER),
		.MAX_DELAY   (MAX_DELAY),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample       (sample),
		.sample_stall (sample_stall),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_stat       (q_stat),
		.push         (q_push),
		.push_win     (push_win),
		.push_ord     (push_ord)
	);

	// window queue
	ope_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({push_ord, push_win}),
		.pop    (q_pop),
		.dout   ({q_ord, q_win}),
		.stat   (q_stat)
	);

	// compare and encode
	ope_back #(
		.MAX_ORDER   (MAX_ORDER),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.q_win        (q_win),
		.q_ord        (q_ord),
		.q_pop        (q_pop),
		.code_valid   (code_valid),
		.pattern_code (pattern_code),
		.code_stall   (code_stall)
	);

`ifndef NO_ASSERTIONS
	// queue never overflows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_stat.count != QCNT_W'(QUEUE_DEPTH)))
		else $error("window queue pushed while full");

	// queue never underflows
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("window queue popped while empty");

	// a full queue holds off new samples
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.count == QCNT_W'(QUEUE_DEPTH)) |-> sample_stall)
		else $error("sample taken while window queue full");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

	localparam int MAX_ORDER   = 8;
	localparam int MAX_DELAY   = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int HIST_DEPTH  = (MAX_ORDER - 1) * MAX_DELAY + 1;
	localparam int DRAIN_WAIT  = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_MODE = 470;

	logic                                   clk;
	logic                                   arst_n       = 1'b0;
	logic                                   sample_valid = 1'b0;
	logic signed [SAMPLE_BITS-1:0]          sample       = '0;
	logic                                   sample_stall;
	logic                                   code_valid;
	logic [ope_pkg::CODE_W-1:0]             pattern_code;
	logic                                   code_stall   = 1'b0;
	logic                                   cfg_we       = 1'b0;
	logic [ope_pkg::CFG_IDX_W-1:0]          cfg_index    = '0;
	logic [ope_pkg::CFG_DATA_W-1:0]         cfg_data     = '0;

	// predictor state: sample history and current settings
	logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];
	int                            hist_head;
	int                            hist_fill;
	logic [ope_pkg::ORD_W-1:0]     order_reg;
	logic [ope_pkg::DLY_CFG_W-1:0] delay_reg;

	logic [ope_pkg::CODE_W-1:0] pending_codes [$];
	int err_count;
	int send_idle_pct;
	int recv_idle_pct;

	ordinal_pattern_encoder_core #(
		.MAX_ORDER  (MAX_ORDER),
		.MAX_DELAY  (MAX_DELAY),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample      (sample),
		.sample_stall(sample_stall),
		.code_valid  (code_valid),
		.pattern_code(pattern_code),
		.code_stall  (code_stall),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top: errors");
		$finish;
	end

	// store a sample and queue the lehmer code of the newest window, if complete
	function automatic void predict_pattern(input logic signed [SAMPLE_BITS-1:0] s);
		logic signed [SAMPLE_BITS-1:0] win [MAX_ORDER];
		int m;
		int tau;
		int smaller;
		int code;
		hist_mem[hist_head] = s;
		hist_head = (hist_head + 1) % HIST_DEPTH;
		if (hist_fill < HIST_DEPTH)
			hist_fill++;
		m   = (order_reg < 2) ? 2 : (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
		tau = (delay_reg < 1) ? 1 : (delay_reg > MAX_DELAY) ? MAX_DELAY : int'(delay_reg);
		if (hist_fill < (m - 1) * tau + 1)
			return;
		for (int i = 0; i < m; i++)
			win[i] = hist_mem[(hist_head + HIST_DEPTH - 1 - (m - 1 - i) * tau) % HIST_DEPTH];
		// horner form of sum smaller_i * (m-1-i)!
		code = 0;
		for (int i = 0; i < m; i++) begin
			smaller = 0;
			for (int j = i + 1; j < m; j++)
				if (win[j] < win[i])
					smaller++;
			code = code * (m - i) + smaller;
		end
		pending_codes.push_back(code[ope_pkg::CODE_W-1:0]);
	endfunction

	// send one sample item, with random idle cycles ahead of it
	task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] s);
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (sample_stall);
		predict_pattern(s);
	endtask

	// stop sending and wait until the pipeline is empty
	task automatic settle();
		sample_valid <= 1'b0;
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// write both settings back to back; block must be idle
	task automatic set_config(input logic [ope_pkg::CFG_DATA_W-1:0] order_data,
	                          input logic [ope_pkg::CFG_DATA_W-1:0] delay_data);
		cfg_we    <= 1'b1;
		cfg_index <= ope_pkg::REG_EMBED_ORDER;
		cfg_data  <= order_data;
		@(posedge clk);
		cfg_index <= ope_pkg::REG_EMBED_DELAY;
		cfg_data  <= delay_data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		order_reg = order_data[ope_pkg::ORD_W-1:0];
		delay_reg = delay_data;
	endtask

	// result side: random stall and compare against the oldest pending code
	always @(posedge clk) begin
		if (code_valid && !code_stall) begin
			if (pending_codes.size() == 0) begin
				$error("pattern_code: expected none, actual %0d", pattern_code);
				err_count++;
			end else begin
				logic [ope_pkg::CODE_W-1:0] want;
				want = pending_codes.pop_front();
				if (pattern_code !== want) begin
					$error("pattern_code: expected %0d, actual %0d", want, pattern_code);
					err_count++;
				end
			end
		end
		code_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// reset settings: window fill, extremes, ties and monotonic runs
	task automatic test_reset_window();
		push_sample(16'sh8000);
		push_sample(16'sh7FFF);
		push_sample(16'sh0000);
		push_sample(-16'sd1);
		push_sample(16'sd1);
		push_sample(16'sd5);
		push_sample(16'sd5);
		push_sample(16'sd5);
		push_sample(16'sd3);
		push_sample(16'sd2);
		push_sample(16'sd1);
		push_sample(16'sh7FFF);
		settle();
	endtask

	// out of range settings are clamped; history survives a settings change
	task automatic test_clamped_settings();
		// order zero with the unused data bit set, delay zero
		set_config(5'h10, 5'h00);
		push_sample(16'sh7FFF);
		push_sample(16'sh8000);
		push_sample(16'sh8000);
		push_sample(-16'sd2);
		settle();
		// order above the maximum, delay two
		set_config(5'h09, 5'h02);
		push_sample(16'sd0);
		push_sample(16'sd0);
		push_sample(-16'sd7);
		push_sample(16'sh8000);
		push_sample(16'sh7FFF);
		push_sample(16'sd0);
		push_sample(16'sd9);
		push_sample(16'sd9);
		settle();
	endtask

	// random stream under three idle patterns and many settings
	task automatic test_random_stream();
		int chunk;
		int mode_items;
		int run_len;
		logic signed [SAMPLE_BITS-1:0] ramp;
		logic signed [SAMPLE_BITS-1:0] s;
		logic [ope_pkg::CFG_DATA_W-1:0] od;
		logic [ope_pkg::CFG_DATA_W-1:0] dd;
		chunk = 0;
		ramp  = '0;
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 86 : 0;
			recv_idle_pct = (mode == 0) ? 86 : (mode == 1) ? 18 : 0;
			mode_items = 0;
			while (mode_items < ITEMS_PER_MODE) begin
				// extremes first, then mostly small delays
				case (chunk)
					0: begin od = 5'h08; dd = 5'h10; end
					1: begin od = 5'h1F; dd = 5'h1F; end
					2: begin od = 5'h02; dd = 5'h01; end
					3: begin od = 5'h01; dd = 5'h00; end
					default: begin
						od = {1'($urandom_range(1)), 4'($urandom_range(15))};
						if ($urandom_range(3) != 0)
							dd = 5'($urandom_range(4));
						else
							dd = 5'($urandom_range(31));
					end
				endcase
				set_config(od, dd);
				run_len = $urandom_range(40, 120);
				for (int k = 0; k < run_len; k++) begin
					// mix of wide values, near ties, extremes and slow ramps
					case ($urandom_range(3))
						0: s = SAMPLE_BITS'($urandom);
						1: s = $signed(16'($urandom_range(4))) - 16'sd2;
						2: begin
							case ($urandom_range(3))
								0: s = 16'sh8000;
								1: s = 16'sh7FFF;
								2: s = 16'sh0000;
								default: s = -16'sd1;
							endcase
						end
						default: begin
							ramp = ramp + $signed(16'($urandom_range(6))) - 16'sd3;
							s = ramp;
						end
					endcase
					push_sample(s);
				end
				mode_items += run_len;
				chunk++;
				settle();
			end
		end
	endtask

	initial begin
		err_count     = 0;
		hist_head     = 0;
		hist_fill     = 0;
		order_reg     = ope_pkg::ORDER_RST;
		delay_reg     = ope_pkg::DELAY_RST;
		send_idle_pct = 18;
		recv_idle_pct = 86;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_clamped_settings();
		test_random_stream();
		settle();
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
